[design/block_video_frame_decoder_unit_defines.svh]
// assertion macros for the video frame decoder
`ifndef BLOCK_VIDEO_FRAME_DECODER_UNIT_DEFINES_SVH
`define BLOCK_VIDEO_FRAME_DECODER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BVFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bvfd assertion failed");
`define BVFD_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("bvfd assertion failed");
`else
`define BVFD_ASSERT(lbl, prop)
`define BVFD_ASSERT_ANY(lbl, prop)
`endif
`endif

[design/bvfd_pkg.sv]
// shared types and constants of the video frame decoder
package bvfd_pkg;

  localparam int unsigned MaxColsDef      = 80;
  localparam int unsigned MaxRowsDef      = 50;
  localparam int unsigned ScreenStrideDef = 320;
  localparam int unsigned SquareSize      = 4;

  localparam int unsigned WidthW  = 7;
  localparam int unsigned HeightW = 6;
  localparam int unsigned CfgW    = 7;

  localparam logic [WidthW-1:0]  WidthReset  = 7'd80;
  localparam logic [HeightW-1:0] HeightReset = 6'd50;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [7:0] CMD_END     = 8'd0;
  localparam logic [7:0] CMD_PALETTE = 8'd1;
  localparam logic [7:0] CMD_CLEAR   = 8'd2;
  localparam logic [7:0] CMD_CODED   = 8'd3;
  localparam logic [7:0] CMD_FILL    = 8'd4;
  localparam logic [7:0] CMD_TWO     = 8'd5;
  localparam logic [7:0] CMD_REDRAW  = 8'd6;

  typedef enum logic [2:0] {
    KIND_PIXEL, KIND_RUN, KIND_FILL, KIND_CLEAR, KIND_PALETTE, KIND_END, KIND_BAD
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] addr;
    logic [7:0]  count;
    logic [7:0]  value;
    logic        mask;
    logic [7:0]  colour_one;
    logic [7:0]  bits;
  } desc_t;

endpackage

[design/bvfd_parse.sv]
// command parser with the square colour store
`include "block_video_frame_decoder_unit_defines.svh"
module bvfd_parse #(
  parameter int unsigned MAX_COLS      = bvfd_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS      = bvfd_pkg::MaxRowsDef,
  parameter int unsigned SCREEN_STRIDE = bvfd_pkg::ScreenStrideDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        frame_start_i,
  input  logic [7:0]                  data_i,
  input  logic [bvfd_pkg::WidthW-1:0]  width_i,
  input  logic [bvfd_pkg::HeightW-1:0] height_i,
  output logic                        init_done_o,
  output logic                        push_o,
  output bvfd_pkg::desc_t             desc_o
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [4:0] PH_CMD = 5'd0, PH_IDLE = 5'd1, PH_CLR = 5'd2, PH_PSTART = 5'd3,
    PH_PCOUNT = 5'd4, PH_PDATA = 5'd5, PH_ROW = 5'd6, PH_COL = 5'd7, PH_SUB = 5'd8,
    PH_LIT = 5'd9, PH_RUNVAL = 5'd10, PH_FILL = 5'd11, PH_C0 = 5'd12, PH_C1 = 5'd13,
    PH_CMLO = 5'd14, PH_CMHI = 5'd15, PH_RMLO = 5'd16, PH_RMHI = 5'd17;

  logic [4:0]  phase_q, phase_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [7:0]  row_q, row_d, col_q, col_d;
  logic [6:0]  rl_q, rl_d, sl_q, sl_d, lit_q, lit_d;
  logic [1:0]  sub_q, sub_d;
  logic [9:0]  spl_q, spl_d;
  logic [15:0] cur_q, cur_d;
  logic [7:0]  run_q, run_d, c0_q, c0_d, c1_q, c1_d;
  logic [10:0] pal_q, pal_d;
  logic [9:0]  pleft_q, pleft_d;

  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic [15:0]   mem [Depth];
  logic [15:0]   rd_q;
  logic          rd_in_q;

  logic [4:0]  ph;
  logic [7:0]  b, mag;
  logic        neg;
  logic [1:0]  sy_sel;
  logic [9:0]  line;
  logic [15:0] scr;
  logic        do_settle, do_start, do_endsub, do_sqphase;
  logic [7:0]  st_row, st_col, nrow;
  logic [6:0]  st_rl, nrl;
  logic        wr_en;
  logic [AW-1:0] wr_idx, rd_idx;
  logic [15:0] wr_data;
  logic        rd_in;

  assign b   = data_i;
  assign neg = b[7];
  assign mag = neg ? 8'(-b) : b;
  assign ph  = frame_start_i ? PH_CMD : phase_q;
  assign init_done_o = !clr_q;

  always_comb begin
    sy_sel = 2'd0;
    if (ph == PH_CMHI || ph == PH_RMHI) begin
      sy_sel = 2'd2;
    end else if (ph == PH_SUB || ph == PH_LIT || ph == PH_RUNVAL) begin
      sy_sel = sub_q + 2'd1;
    end
    line = {row_q, 2'b00} + 10'(sy_sel);
    scr  = 16'(32'(line) * 32'(SCREEN_STRIDE)) + 16'({col_q, 2'b00});
  end

  always_comb begin
    phase_d = phase_q; cmd_d = cmd_q; row_d = row_q; col_d = col_q;
    rl_d = rl_q; sl_d = sl_q; lit_d = lit_q; sub_d = sub_q; spl_d = spl_q;
    cur_d = cur_q; run_d = run_q; c0_d = c0_q; c1_d = c1_q;
    pal_d = pal_q; pleft_d = pleft_q;
    do_settle = 1'b0; do_start = 1'b0; do_endsub = 1'b0; do_sqphase = 1'b0;
    st_row = row_q; st_col = col_q; st_rl = rl_q;
    nrow = row_q; nrl = rl_q;
    push_o = 1'b0;
    desc_o = '{kind: bvfd_pkg::KIND_PIXEL, addr: 16'd0, count: 8'd0, value: b,
               mask: 1'b0, colour_one: c1_q, bits: b};
    if (accept_i) begin
      phase_d = ph;
      unique case (ph)
        PH_CMD: begin
          if (b == bvfd_pkg::CMD_END) begin
            push_o = 1'b1; desc_o.kind = bvfd_pkg::KIND_END; desc_o.value = 8'd0;
            phase_d = PH_IDLE;
          end else if (b == bvfd_pkg::CMD_PALETTE) begin
            phase_d = PH_PSTART;
          end else if (b == bvfd_pkg::CMD_CLEAR) begin
            phase_d = PH_CLR;
          end else if (b <= bvfd_pkg::CMD_REDRAW) begin
            cmd_d = b[2:0];
            row_d = 8'd0; col_d = 8'd0; rl_d = 7'd0; sl_d = 7'd0; sub_d = 2'd0;
            st_row = 8'd0; st_col = 8'd0; st_rl = 7'd0;
            do_settle = 1'b1;
          end else begin
            push_o = 1'b1; desc_o.kind = bvfd_pkg::KIND_BAD; desc_o.value = 8'd0;
            phase_d = PH_IDLE;
          end
        end
        PH_IDLE: ;
        PH_CLR: begin
          push_o = 1'b1; desc_o.kind = bvfd_pkg::KIND_CLEAR;
          phase_d = PH_CMD;
        end
        PH_PSTART: begin
          pal_d = 11'(b) * 11'd3;
          phase_d = PH_PCOUNT;
        end
        PH_PCOUNT: begin
          pleft_d = (b == 8'd0) ? 10'd768 : 10'(b) * 10'd3;
          phase_d = PH_PDATA;
        end
        PH_PDATA: begin
          push_o = 1'b1; desc_o.kind = bvfd_pkg::KIND_PALETTE;
          desc_o.addr = 16'(pal_q);
          pal_d = pal_q + 11'd1;
          pleft_d = pleft_q - 10'd1;
          if (pleft_d == 10'd0) phase_d = PH_CMD;
        end
        PH_ROW: begin
          if (b != 8'd0 && !neg) begin
            rl_d = b[6:0]; col_d = 8'd0;
          end else begin
            row_d = row_q + mag;
          end
          st_row = row_d; st_col = col_d; st_rl = rl_d;
          do_settle = 1'b1;
        end
        PH_COL: begin
          if (b != 8'd0 && !neg) begin
            sl_d = b[6:0];
            if (cmd_q == bvfd_pkg::CMD_CODED[2:0]) begin
              sub_d = 2'd0; do_start = 1'b1;
            end else begin
              do_sqphase = 1'b1;
            end
          end else begin
            col_d = col_q + mag;
            st_col = col_d;
            do_settle = 1'b1;
          end
        end
        PH_SUB: begin
          if (b == 8'd0) begin
            do_endsub = 1'b1;
          end else if (!neg) begin
            lit_d = b[6:0];
            spl_d = ({2'b00, b} >= spl_q) ? 10'd0 : spl_q - {2'b00, b};
            phase_d = PH_LIT;
          end else begin
            run_d = mag;
            phase_d = PH_RUNVAL;
          end
        end
        PH_LIT: begin
          push_o = 1'b1; desc_o.addr = cur_q;
          cur_d = cur_q + 16'd1;
          lit_d = lit_q - 7'd1;
          if (lit_d == 7'd0) begin
            if (spl_q == 10'd0) do_endsub = 1'b1;
            else phase_d = PH_SUB;
          end
        end
        PH_RUNVAL: begin
          push_o = 1'b1; desc_o.kind = bvfd_pkg::KIND_RUN;
          desc_o.addr = cur_q; desc_o.count = run_q;
          cur_d = cur_q + 16'(run_q);
          spl_d = ({2'b00, run_q} >= spl_q) ? 10'd0 : spl_q - {2'b00, run_q};
          if (spl_d == 10'd0) do_endsub = 1'b1;
          else phase_d = PH_SUB;
        end
        PH_FILL: begin
          push_o = 1'b1; desc_o.kind = bvfd_pkg::KIND_FILL; desc_o.addr = scr;
          col_d = col_q + 8'd1;
          sl_d = sl_q - 7'd1;
          if (sl_d != 7'd0) do_sqphase = 1'b1;
          else begin st_col = col_d; st_rl = rl_q; do_settle = 1'b1; end
        end
        PH_C0: begin
          c0_d = b; phase_d = PH_C1;
        end
        PH_C1: begin
          c1_d = b; phase_d = PH_CMLO;
        end
        PH_CMLO, PH_RMLO: begin
          if (ph == PH_RMLO) begin
            c0_d = rd_in_q ? rd_q[7:0] : 8'd0;
            c1_d = rd_in_q ? rd_q[15:8] : 8'd0;
          end
          push_o = 1'b1; desc_o.mask = 1'b1; desc_o.addr = scr;
          desc_o.value = c0_d; desc_o.colour_one = c1_d;
          phase_d = (ph == PH_RMLO) ? PH_RMHI : PH_CMHI;
        end
        PH_CMHI, PH_RMHI: begin
          push_o = 1'b1; desc_o.mask = 1'b1; desc_o.addr = scr;
          desc_o.value = c0_q; desc_o.colour_one = c1_q;
          col_d = col_q + 8'd1;
          sl_d = sl_q - 7'd1;
          if (sl_d != 7'd0) do_sqphase = 1'b1;
          else begin st_col = col_d; st_rl = rl_q; do_settle = 1'b1; end
        end
        default: phase_d = PH_IDLE;
      endcase

      if (do_endsub) begin
        if (sub_q == 2'd3) begin
          sub_d = 2'd0;
          col_d = col_q + {1'b0, sl_q};
          sl_d = 7'd0;
          st_row = row_q; st_col = col_d; st_rl = rl_q;
          do_settle = 1'b1;
        end else begin
          sub_d = sub_q + 2'd1;
          do_start = 1'b1;
        end
      end
      if (do_start) begin
        spl_d = 10'({sl_d, 2'b00});
        cur_d = scr;
        phase_d = PH_SUB;
      end
      if (do_sqphase) begin
        if (cmd_q == bvfd_pkg::CMD_FILL[2:0]) phase_d = PH_FILL;
        else if (cmd_q == bvfd_pkg::CMD_TWO[2:0]) phase_d = PH_C0;
        else phase_d = PH_RMLO;
      end
      if (do_settle) begin
        nrow = st_row; nrl = st_rl;
        if (st_rl != 7'd0) begin
          if (st_col < {1'b0, width_i}) begin
            phase_d = PH_COL;
          end else begin
            col_d = 8'd0;
            if (width_i == '0) begin
              nrow = st_row + {1'b0, st_rl};
              nrl = 7'd0;
            end else begin
              nrow = st_row + 8'd1;
              nrl = st_rl - 7'd1;
            end
            row_d = nrow; rl_d = nrl;
            if (nrl != 7'd0) phase_d = PH_COL;
            else phase_d = (nrow < {2'b00, height_i}) ? PH_ROW : PH_CMD;
          end
        end else begin
          phase_d = (st_row < {2'b00, height_i}) ? PH_ROW : PH_CMD;
        end
      end
    end
  end

  always_comb begin
    rd_in   = (32'(row_d) < MAX_ROWS) && (32'(col_d) < MAX_COLS);
    rd_idx  = AW'(32'(row_d) * 32'(MAX_COLS) + 32'(col_d));
    wr_en   = clr_q ||
              (accept_i && ph == PH_C1 &&
               (32'(row_q) < MAX_ROWS) && (32'(col_q) < MAX_COLS));
    wr_idx  = clr_q ? clr_cnt_q : AW'(32'(row_q) * 32'(MAX_COLS) + 32'(col_q));
    wr_data = clr_q ? 16'd0 : {b, c0_q};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    rd_q    <= mem[rd_idx];
    rd_in_q <= rd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (32'(clr_cnt_q) == Depth - 1) clr_q <= 1'b0;
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD; cmd_q <= '0; row_q <= '0; col_q <= '0;
      rl_q <= '0; sl_q <= '0; lit_q <= '0; sub_q <= '0; spl_q <= '0;
      cur_q <= '0; run_q <= '0; c0_q <= '0; c1_q <= '0;
      pal_q <= '0; pleft_q <= '0;
    end else begin
      phase_q <= phase_d; cmd_q <= cmd_d; row_q <= row_d; col_q <= col_d;
      rl_q <= rl_d; sl_q <= sl_d; lit_q <= lit_d; sub_q <= sub_d; spl_q <= spl_d;
      cur_q <= cur_d; run_q <= run_d; c0_q <= c0_d; c1_q <= c1_d;
      pal_q <= pal_d; pleft_q <= pleft_d;
    end
  end

  `BVFD_ASSERT(a_no_accept_in_clear, clr_q |-> !accept_i)
  `BVFD_ASSERT_ANY(a_push_needs_accept, push_o |-> accept_i)
  `BVFD_ASSERT(a_idle_holds,
    (accept_i && phase_q == PH_IDLE && !frame_start_i) |=> phase_q == PH_IDLE)

endmodule

[design/bvfd_emit.sv]
// result queue and pixel burst serializer
`include "block_video_frame_decoder_unit_defines.svh"
module bvfd_emit #(
  parameter int unsigned SCREEN_STRIDE = bvfd_pkg::ScreenStrideDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bvfd_pkg::desc_t desc_i,
  output logic            space_o,
  output logic            valid_o,
  input  logic            ready_i,
  output bvfd_pkg::kind_e kind_o,
  output logic [15:0]     addr_o,
  output logic [7:0]      count_o,
  output logic [7:0]      value_o,
  output logic            last_o
);

  bvfd_pkg::desc_t ent_q [2];
  bvfd_pkg::desc_t head;
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [2:0] idx_q;
  logic       pop;

  assign head    = ent_q[rp_q];
  assign valid_o = cnt_q != 2'd0;
  assign space_o = cnt_q != 2'd2;
  assign kind_o  = head.kind;
  assign count_o = head.count;
  assign last_o  = !head.mask || idx_q == 3'd7;
  assign addr_o  = head.mask ?
                   head.addr + (idx_q[2] ? 16'(SCREEN_STRIDE) : 16'd0) + 16'(idx_q[1:0]) :
                   head.addr;
  assign value_o = (head.mask && head.bits[idx_q]) ? head.colour_one : head.value;
  assign pop     = valid_o && ready_i && last_o;

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0; idx_q <= 3'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
      if (valid_o && ready_i) idx_q <= last_o ? 3'd0 : idx_q + 3'd1;
    end
  end

  `BVFD_ASSERT(a_no_overflow, push_i |-> cnt_q != 2'd2)
  `BVFD_ASSERT(a_idx_mask_only, idx_q != 3'd0 |-> (valid_o && head.mask))
  `BVFD_ASSERT(a_stall_holds_idx, (valid_o && !ready_i) |=> $stable(idx_q))

endmodule

[design/block_video_frame_decoder_unit.sv]
// top level of the video frame decoder
// Frame body bytes enter on the s_axis channel, one byte per request: tdata holds
// the byte, tuser marks the first byte of a frame body and restarts the parser.
// Results leave on the m_axis channel; tuser carries the result kind and tlast
// marks the final result of one byte.
// Width and height in squares are set on the cfg port, by the user only while
// the block is idle; the block does not enforce this. A byte is taken every
// cycle while the result queue has space. Most bytes give at most one result;
// a mask byte of the two-colour and redraw commands gives eight pixel results,
// one per cycle while the receiver is ready, so input waits on a full queue.
// The stored square colours live in a one-port-write, one-port-read memory
// read into a register ahead of the redraw mask byte.
// After reset the colour store is swept to zero, one entry per cycle;
// it has MAX_ROWS*MAX_COLS entries (4000 by default). s_axis_tready stays low
// during the sweep. A two-entry result queue decouples the sides: when the
// receiver stalls, input continues until the queue is full and then stops.
module block_video_frame_decoder_unit #(
  parameter int unsigned MAX_COLS      = bvfd_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS      = bvfd_pkg::MaxRowsDef,
  parameter int unsigned SCREEN_STRIDE = bvfd_pkg::ScreenStrideDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [bvfd_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [7:0]               s_axis_tdata_i,   // data_byte
  input  logic                     s_axis_tuser_i,   // frame_start
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [31:0]              m_axis_tdata_o,   // address, count, value
  output logic [2:0]               m_axis_tuser_o,   // kind
  output logic                     m_axis_tlast_o
);

  logic [bvfd_pkg::WidthW-1:0]  width_q;
  logic [bvfd_pkg::HeightW-1:0] height_q;
  logic            init_done, space, accept, push;
  bvfd_pkg::desc_t desc;
  bvfd_pkg::kind_e kind;
  logic [15:0]     addr;
  logic [7:0]      count, value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bvfd_pkg::WidthReset;
      height_q <= bvfd_pkg::HeightReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bvfd_pkg::CFG_WIDTH) width_q <= cfg_wdata_i[bvfd_pkg::WidthW-1:0];
      if (cfg_idx_i == bvfd_pkg::CFG_HEIGHT) height_q <= cfg_wdata_i[bvfd_pkg::HeightW-1:0];
    end
  end

  assign s_axis_tready_o = init_done && space;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  bvfd_parse #(
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .SCREEN_STRIDE(SCREEN_STRIDE)
  ) u_parse (
    .clk_i, .rst_ni,
    .accept_i(accept), .frame_start_i(s_axis_tuser_i), .data_i(s_axis_tdata_i),
    .width_i(width_q), .height_i(height_q),
    .init_done_o(init_done), .push_o(push), .desc_o(desc)
  );

  bvfd_emit #(.SCREEN_STRIDE(SCREEN_STRIDE)) u_emit (
    .clk_i, .rst_ni,
    .push_i(push), .desc_i(desc), .space_o(space),
    .valid_o(m_axis_tvalid_o), .ready_i(m_axis_tready_i),
    .kind_o(kind), .addr_o(addr), .count_o(count), .value_o(value),
    .last_o(m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {value, count, addr};
  assign m_axis_tuser_o = kind;

endmodule
